@@ rtl/tgr_pkg.sv @@
// ----------------------------------------------------------------------------
// tgr_pkg: shared types, constants and the control store of the glyph renderer
// Holds field widths, command and register codes, the datapath control word
// and the microprogram that sequences one word through the datapath.
// ----------------------------------------------------------------------------
package tgr_pkg;

  // Table geometry.
  localparam int MAX_GLYPHS     = 256;
  localparam int MAX_GLYPH_ROWS = 16;
  localparam int MAX_OUT_ROWS   = 16;
  localparam int ROW_LIMIT      = (MAX_GLYPH_ROWS < MAX_OUT_ROWS) ? MAX_GLYPH_ROWS
                                                                  : MAX_OUT_ROWS;
  localparam int GLYPH_AW       = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
  localparam int ROW_AW         = (MAX_GLYPH_ROWS > 1) ? $clog2(MAX_GLYPH_ROWS) : 1;
  localparam int BMP_DEPTH      = MAX_GLYPHS * MAX_GLYPH_ROWS;
  localparam int BMP_AW         = $clog2(BMP_DEPTH);
  localparam int GCOUNT_W       = $clog2(MAX_GLYPHS + 1);

  // Field widths.
  localparam int CMD_W    = 2;
  localparam int CODE_W   = 8;
  localparam int COLOR_W  = 32;
  localparam int BITS_W   = 8;
  localparam int ADDR_W   = 24;
  localparam int PIX_W    = 4;
  localparam int HGT_W    = 5;
  localparam int SPACE_W  = 3;
  localparam int CELLS_W  = 8;
  localparam int PITCH_W  = 13;
  localparam int COUNT_W  = 9;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 13;
  localparam int PROD_W   = CELLS_W + HGT_W;
  localparam int CELL_W   = 4;
  localparam int COLX_W   = CELLS_W + CELL_W;

  // Commands carried by an input word.
  localparam logic [CMD_W-1:0] CMD_DRAW      = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_CODE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD_ROW  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHAR_SPACING   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLUMNS   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_ROWS      = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_PITCH    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_COUNT    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FALLBACK_GLYPH = 4'd7;

  // Character and color constants.
  localparam logic [CODE_W-1:0] ESC_CODE  = 8'h1B;
  localparam logic [7:0]        BOLD_ADD  = 8'h55;
  localparam logic [7:0]        BYTE_MAX  = 8'hFF;
  localparam logic [PIX_W-1:0]  WIDTH_MAX = 4'd8;

  // Configuration register file contents.
  typedef struct packed {
    logic [PIX_W-1:0]   glyph_width;
    logic [HGT_W-1:0]   glyph_height;
    logic [SPACE_W-1:0] char_spacing;
    logic [CELLS_W-1:0] text_columns;
    logic [CELLS_W-1:0] text_rows;
    logic [PITCH_W-1:0] frame_pitch;
    logic [COUNT_W-1:0] glyph_count;
    logic [CODE_W-1:0]  fallback_glyph;
  } cfg_t;

  // Datapath operations, one per microinstruction.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_FETCH,
    OP_STORE,
    OP_PREP,
    OP_SCALE,
    OP_OFFSET,
    OP_SEARCH,
    OP_RESOLVE,
    OP_ROW_READ,
    OP_EMIT,
    OP_ESC
  } dp_op_e;

  // Jump conditions.
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_NOT_DRAW,
    C_ESC,
    C_SEARCHING,
    C_ROW_MORE
  } cond_e;

  // Program counter and step addresses.
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] STEP_FETCH    = 4'd0;
  localparam logic [PC_W-1:0] STEP_DISPATCH = 4'd1;
  localparam logic [PC_W-1:0] STEP_PREP     = 4'd2;
  localparam logic [PC_W-1:0] STEP_SCALE    = 4'd3;
  localparam logic [PC_W-1:0] STEP_OFFSET   = 4'd4;
  localparam logic [PC_W-1:0] STEP_SEARCH   = 4'd5;
  localparam logic [PC_W-1:0] STEP_RESOLVE  = 4'd6;
  localparam logic [PC_W-1:0] STEP_ROW_READ = 4'd7;
  localparam logic [PC_W-1:0] STEP_EMIT     = 4'd8;
  localparam logic [PC_W-1:0] STEP_DONE     = 4'd9;
  localparam logic [PC_W-1:0] STEP_ESC      = 4'd10;

  // One control word of the microprogram.
  typedef struct packed {
    dp_op_e          op;
    cond_e           cond;
    logic [PC_W-1:0] target;
    logic            wait_out;
  } ucode_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    dp_op_e op;
    logic   fire;
  } ctrl_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic in_valid;
    logic is_draw;
    logic is_esc;
    logic searching;
    logic row_more;
    logic out_busy;
  } status_t;

  // The microprogram. A taken condition jumps to the target, else the
  // counter steps on; a step with wait_out holds while the output is full.
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{op: OP_NONE, cond: C_ALWAYS, target: STEP_FETCH, wait_out: 1'b0};
    case (pc)
      STEP_FETCH:    w = '{op: OP_FETCH, cond: C_NO_INPUT, target: STEP_FETCH,
                           wait_out: 1'b0};
      STEP_DISPATCH: w = '{op: OP_STORE, cond: C_NOT_DRAW, target: STEP_FETCH,
                           wait_out: 1'b0};
      STEP_PREP:     w = '{op: OP_PREP, cond: C_ESC, target: STEP_ESC,
                           wait_out: 1'b0};
      STEP_SCALE:    w = '{op: OP_SCALE, cond: C_NEVER, target: STEP_FETCH,
                           wait_out: 1'b0};
      STEP_OFFSET:   w = '{op: OP_OFFSET, cond: C_NEVER, target: STEP_FETCH,
                           wait_out: 1'b0};
      STEP_SEARCH:   w = '{op: OP_SEARCH, cond: C_SEARCHING, target: STEP_SEARCH,
                           wait_out: 1'b0};
      STEP_RESOLVE:  w = '{op: OP_RESOLVE, cond: C_NEVER, target: STEP_FETCH,
                           wait_out: 1'b0};
      STEP_ROW_READ: w = '{op: OP_ROW_READ, cond: C_NEVER, target: STEP_FETCH,
                           wait_out: 1'b0};
      STEP_EMIT:     w = '{op: OP_EMIT, cond: C_ROW_MORE, target: STEP_ROW_READ,
                           wait_out: 1'b1};
      STEP_DONE:     w = '{op: OP_NONE, cond: C_ALWAYS, target: STEP_FETCH,
                           wait_out: 1'b0};
      STEP_ESC:      w = '{op: OP_ESC, cond: C_ALWAYS, target: STEP_FETCH,
                           wait_out: 1'b1};
      default:       w = '{op: OP_NONE, cond: C_ALWAYS, target: STEP_FETCH,
                           wait_out: 1'b0};
    endcase
    return w;
  endfunction

  // Bold text color: each byte gets BOLD_ADD with saturation.
  function automatic logic [COLOR_W-1:0] brighten(input logic [COLOR_W-1:0] c);
    logic [COLOR_W-1:0] r;
    logic [8:0]         v;
    r = '0;
    for (int b = 0; b < COLOR_W / 8; b++) begin
      v = {1'b0, c[8*b +: 8]} + {1'b0, BOLD_ADD};
      r[8*b +: 8] = v[8] ? BYTE_MAX : v[7:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/tgr_chan_if.sv @@
// ----------------------------------------------------------------------------
// tgr channel interfaces
// Valid/ready channels of the glyph renderer: command words in, row words
// out, and the configuration write channel.
// ----------------------------------------------------------------------------
interface tgr_cmd_if;
  import tgr_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [CODE_W-1:0]   char_code;
  logic [COLOR_W-1:0]  fore_color;
  logic [COLOR_W-1:0]  back_color;
  logic                bold;
  logic [GLYPH_AW-1:0] entry_index;
  logic [ROW_AW-1:0]   row_index;
  logic [BITS_W-1:0]   row_bits;

  modport source (output valid, command, char_code, fore_color, back_color, bold,
                  entry_index, row_index, row_bits, input ready);
  modport sink (input valid, command, char_code, fore_color, back_color, bold,
                entry_index, row_index, row_bits, output ready);
endinterface

interface tgr_row_if;
  import tgr_pkg::*;

  logic               valid;
  logic               ready;
  logic [ADDR_W-1:0]  pixel_address;
  logic [BITS_W-1:0]  pixel_mask;
  logic [PIX_W-1:0]   row_pixels;
  logic [COLOR_W-1:0] text_color;
  logic [COLOR_W-1:0] fill_color;
  logic               last_row;
  logic               scroll_request;
  logic               escape_seen;

  modport source (output valid, pixel_address, pixel_mask, row_pixels, text_color,
                  fill_color, last_row, scroll_request, escape_seen, input ready);
  modport sink (input valid, pixel_address, pixel_mask, row_pixels, text_color,
                fill_color, last_row, scroll_request, escape_seen, output ready);
endinterface

interface tgr_cfg_if;
  import tgr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/text_glyph_row_renderer.sv @@
// ----------------------------------------------------------------------------
// text_glyph_row_renderer: text-mode glyph row renderer, top level
// A draw searches the code table and then emits one output word per glyph
// row; the code table RAM read port sets the search rate of one entry per
// cycle. Loads, unused commands and escapes run shorter programs; the
// block takes one word at a time.
// Reset clears the cursor, the sequencer and the registers to their defaults;
// the glyph tables are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module text_glyph_row_renderer (
  input  logic       clk_i,
  input  logic       rst_ni,
  tgr_cmd_if.sink    cmd_in,
  tgr_row_if.source  row_out,
  tgr_cfg_if.sink    cfg_in
);
  import tgr_pkg::*;

  cfg_t    cfg_q;
  ctrl_t   ctrl;
  status_t status;

  assign cfg_in.ready = 1'b1;

  // Configuration register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.glyph_width    <= PIX_W'(8);
      cfg_q.glyph_height   <= HGT_W'(16);
      cfg_q.char_spacing   <= '0;
      cfg_q.text_columns   <= CELLS_W'(80);
      cfg_q.text_rows      <= CELLS_W'(25);
      cfg_q.frame_pitch    <= PITCH_W'(1024);
      cfg_q.glyph_count    <= '0;
      cfg_q.fallback_glyph <= '0;
    end else if (cfg_in.valid) begin
      case (cfg_in.index)
        REG_GLYPH_WIDTH:    cfg_q.glyph_width    <= cfg_in.data[PIX_W-1:0];
        REG_GLYPH_HEIGHT:   cfg_q.glyph_height   <= cfg_in.data[HGT_W-1:0];
        REG_CHAR_SPACING:   cfg_q.char_spacing   <= cfg_in.data[SPACE_W-1:0];
        REG_TEXT_COLUMNS:   cfg_q.text_columns   <= cfg_in.data[CELLS_W-1:0];
        REG_TEXT_ROWS:      cfg_q.text_rows      <= cfg_in.data[CELLS_W-1:0];
        REG_FRAME_PITCH:    cfg_q.frame_pitch    <= cfg_in.data[PITCH_W-1:0];
        REG_GLYPH_COUNT:    cfg_q.glyph_count    <= cfg_in.data[COUNT_W-1:0];
        REG_FALLBACK_GLYPH: cfg_q.fallback_glyph <= cfg_in.data[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Microprogram sequencer.
  tgr_sequencer u_sequencer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  // Datapath with glyph tables and output register.
  tgr_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .ctrl_i   (ctrl),
    .status_o (status),
    .cmd_in   (cmd_in),
    .row_out  (row_out)
  );

endmodule

@@ rtl/tgr_ram.sv @@
// ----------------------------------------------------------------------------
// tgr_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered and holds
// between read strobes.
// ----------------------------------------------------------------------------
module tgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/tgr_sequencer.sv @@
// ----------------------------------------------------------------------------
// tgr_sequencer: microprogram counter of the glyph renderer
// Fetches one control word per step from the control store, evaluates its
// jump condition against datapath status and holds on output back-pressure.
// ----------------------------------------------------------------------------
module tgr_sequencer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tgr_pkg::status_t status_i,
  output tgr_pkg::ctrl_t   ctrl_o
);
  import tgr_pkg::*;

  logic [PC_W-1:0] pc_q, pc_d;
  ucode_t          word;
  logic            stall;
  logic            take;

  assign word  = ucode_rom(pc_q);
  assign stall = word.wait_out && status_i.out_busy;

  // Jump condition select.
  always_comb begin
    case (word.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NO_INPUT:  take = !status_i.in_valid;
      C_NOT_DRAW:  take = !status_i.is_draw;
      C_ESC:       take = status_i.is_esc;
      C_SEARCHING: take = status_i.searching;
      C_ROW_MORE:  take = status_i.row_more;
      default:     take = 1'b0;
    endcase
  end

  // Next step: hold, jump or step on.
  always_comb begin
    if (stall) begin
      pc_d = pc_q;
    end else if (take) begin
      pc_d = word.target;
    end else begin
      pc_d = pc_q + PC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_FETCH;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o.op   = word.op;
  assign ctrl_o.fire = !stall;

`ifndef SYNTHESIS
  // The program never leaves its defined steps.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pc_q <= STEP_ESC)
    else $error("sequencer left the program");
`endif

endmodule

@@ rtl/tgr_datapath.sv @@
// ----------------------------------------------------------------------------
// tgr_datapath: glyph search, address arithmetic and row output
// Executes one operation per microstep: latches a word, loads the glyph
// tables, scales the cursor into a pixel address, searches the code table
// and emits one output word per glyph row, or one escape word, through an output register.
// ----------------------------------------------------------------------------
module tgr_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tgr_pkg::cfg_t    cfg_i,
  input  tgr_pkg::ctrl_t   ctrl_i,
  output tgr_pkg::status_t status_o,
  tgr_cmd_if.sink          cmd_in,
  tgr_row_if.source        row_out
);
  import tgr_pkg::*;

  // Latched input word.
  logic [CMD_W-1:0]    cmd_q;
  logic [CODE_W-1:0]   code_q;
  logic [COLOR_W-1:0]  fore_q;
  logic [COLOR_W-1:0]  back_q;
  logic                bold_q;
  logic [GLYPH_AW-1:0] entry_q;
  logic [ROW_AW-1:0]   rowi_q;
  logic [BITS_W-1:0]   bits_q;

  // Working registers.
  logic [COLOR_W-1:0]  tcol_q;
  logic [PIX_W-1:0]    w_q;
  logic [HGT_W-1:0]    h_q;
  logic [GCOUNT_W-1:0] n_q;
  logic [PROD_W-1:0]   prod_q;
  logic [COLX_W-1:0]   colx_q;
  logic [ADDR_W-1:0]   acc_q;
  logic [GCOUNT_W-1:0] idx_q;
  logic [GLYPH_AW-1:0] g_q;
  logic [ROW_AW-1:0]   j_q;
  logic                scroll_q;
  logic [CELLS_W-1:0]  cur_col_q;
  logic [CELLS_W-1:0]  cur_line_q;

  // Output register.
  logic                out_valid_q;
  logic [ADDR_W-1:0]   out_addr_q;
  logic [BITS_W-1:0]   out_mask_q;
  logic [PIX_W-1:0]    out_pix_q;
  logic [COLOR_W-1:0]  out_text_q;
  logic [COLOR_W-1:0]  out_fill_q;
  logic                out_last_q;
  logic                out_scroll_q;
  logic                out_esc_q;

  // Operation strobes.
  logic go_fetch, go_store, go_prep, go_scale, go_offset;
  logic go_search, go_resolve, go_read, go_emit, go_esc;
  logic accept;

  assign go_fetch   = ctrl_i.fire && (ctrl_i.op == OP_FETCH);
  assign go_store   = ctrl_i.fire && (ctrl_i.op == OP_STORE);
  assign go_prep    = ctrl_i.fire && (ctrl_i.op == OP_PREP);
  assign go_scale   = ctrl_i.fire && (ctrl_i.op == OP_SCALE);
  assign go_offset  = ctrl_i.fire && (ctrl_i.op == OP_OFFSET);
  assign go_search  = ctrl_i.fire && (ctrl_i.op == OP_SEARCH);
  assign go_resolve = ctrl_i.fire && (ctrl_i.op == OP_RESOLVE);
  assign go_read    = ctrl_i.fire && (ctrl_i.op == OP_ROW_READ);
  assign go_emit    = ctrl_i.fire && (ctrl_i.op == OP_EMIT);
  assign go_esc     = ctrl_i.fire && (ctrl_i.op == OP_ESC);

  assign cmd_in.ready = go_fetch;
  assign accept       = go_fetch && cmd_in.valid;

  // Clamped geometry taken from the registers.
  logic [PIX_W-1:0]    w_eff;
  logic [HGT_W-1:0]    h_eff;
  logic [GCOUNT_W-1:0] n_eff;
  logic [GLYPH_AW-1:0] fallback_sel;

  always_comb begin
    if (cfg_i.glyph_width == '0) begin
      w_eff = PIX_W'(1);
    end else if (cfg_i.glyph_width > WIDTH_MAX) begin
      w_eff = WIDTH_MAX;
    end else begin
      w_eff = cfg_i.glyph_width;
    end
    if (cfg_i.glyph_height == '0) begin
      h_eff = HGT_W'(1);
    end else if (32'(cfg_i.glyph_height) > ROW_LIMIT) begin
      h_eff = HGT_W'(ROW_LIMIT);
    end else begin
      h_eff = cfg_i.glyph_height;
    end
    if (32'(cfg_i.glyph_count) > MAX_GLYPHS) begin
      n_eff = GCOUNT_W'(MAX_GLYPHS);
    end else begin
      n_eff = GCOUNT_W'(cfg_i.glyph_count);
    end
    if (32'(cfg_i.fallback_glyph) < MAX_GLYPHS) begin
      fallback_sel = GLYPH_AW'(cfg_i.fallback_glyph);
    end else begin
      fallback_sel = '0;
    end
  end

  // Address products: line times height times pitch, column times cell width.
  logic [PROD_W+PITCH_W-1:0] scaled;
  logic [CELL_W-1:0]         cell_w;
  logic [COLX_W-1:0]         col_off;
  logic [PROD_W-1:0]         line_rows;

  assign line_rows = cur_line_q * h_eff;
  assign scaled    = prod_q * cfg_i.frame_pitch;
  assign cell_w    = w_q + CELL_W'(cfg_i.char_spacing);
  assign col_off   = cur_col_q * cell_w;

  // Cursor advance with wrap and scroll.
  logic [CELLS_W:0]   col_inc;
  logic [CELLS_W:0]   line_inc;
  logic [CELLS_W-1:0] col_next;
  logic [CELLS_W-1:0] line_next;
  logic               scroll_next;

  always_comb begin
    col_inc     = {1'b0, cur_col_q} + (CELLS_W+1)'(1);
    line_inc    = {1'b0, cur_line_q};
    scroll_next = 1'b0;
    if (col_inc >= {1'b0, cfg_i.text_columns}) begin
      col_inc  = '0;
      line_inc = line_inc + (CELLS_W+1)'(1);
    end
    col_next = col_inc[CELLS_W-1:0];
    if (line_inc >= {1'b0, cfg_i.text_rows}) begin
      scroll_next = 1'b1;
      line_next   = (cfg_i.text_rows != '0) ? cfg_i.text_rows - CELLS_W'(1) : '0;
    end else begin
      line_next = line_inc[CELLS_W-1:0];
    end
  end

  // Glyph tables.
  logic [CODE_W-1:0]   code_rdata;
  logic [BITS_W-1:0]   bmp_rdata;
  logic                code_we, bmp_we, code_re;
  logic [GLYPH_AW-1:0] code_raddr;
  logic [BMP_AW-1:0]   bmp_waddr, bmp_raddr;
  logic                searching;
  logic                row_last;

  assign code_we    = go_store && (cmd_q == CMD_LOAD_CODE) && (32'(entry_q) < MAX_GLYPHS);
  assign bmp_we     = go_store && (cmd_q == CMD_LOAD_ROW) && (32'(entry_q) < MAX_GLYPHS)
                      && (32'(rowi_q) < MAX_GLYPH_ROWS);
  assign bmp_waddr  = BMP_AW'(32'(entry_q) * MAX_GLYPH_ROWS + 32'(rowi_q));
  assign bmp_raddr  = BMP_AW'(32'(g_q) * MAX_GLYPH_ROWS + 32'(j_q));
  assign searching  = !((idx_q >= n_q) || (code_rdata == code_q));
  assign code_re    = go_offset || (go_search && searching);
  assign code_raddr = go_offset ? '0 : GLYPH_AW'(idx_q + GCOUNT_W'(1));
  assign row_last   = ((HGT_W'(j_q) + HGT_W'(1)) == h_q);

  tgr_ram #(
    .WIDTH (CODE_W),
    .DEPTH (MAX_GLYPHS)
  ) u_code_ram (
    .clk_i   (clk_i),
    .we_i    (code_we),
    .waddr_i (entry_q),
    .wdata_i (code_q),
    .re_i    (code_re),
    .raddr_i (code_raddr),
    .rdata_o (code_rdata)
  );

  tgr_ram #(
    .WIDTH (BITS_W),
    .DEPTH (BMP_DEPTH)
  ) u_bitmap_ram (
    .clk_i   (clk_i),
    .we_i    (bmp_we),
    .waddr_i (bmp_waddr),
    .wdata_i (bits_q),
    .re_i    (go_read),
    .raddr_i (bmp_raddr),
    .rdata_o (bmp_rdata)
  );

  // Control state: cursor and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q   <= '0;
      cur_line_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (go_offset) begin
        cur_col_q  <= col_next;
        cur_line_q <= line_next;
      end
      if (go_emit || go_esc) begin
        out_valid_q <= 1'b1;
      end else if (row_out.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_in.command;
      code_q  <= cmd_in.char_code;
      fore_q  <= cmd_in.fore_color;
      back_q  <= cmd_in.back_color;
      bold_q  <= cmd_in.bold;
      entry_q <= cmd_in.entry_index;
      rowi_q  <= cmd_in.row_index;
      bits_q  <= cmd_in.row_bits;
    end
    if (go_prep) begin
      tcol_q <= bold_q ? brighten(fore_q) : fore_q;
      w_q    <= w_eff;
      h_q    <= h_eff;
      n_q    <= n_eff;
      prod_q <= line_rows;
    end
    if (go_scale) begin
      acc_q  <= scaled[ADDR_W-1:0];
      colx_q <= col_off;
    end
    if (go_offset) begin
      acc_q    <= acc_q + ADDR_W'(colx_q);
      scroll_q <= scroll_next;
      idx_q    <= '0;
    end
    if (go_search && searching) begin
      idx_q <= idx_q + GCOUNT_W'(1);
    end
    if (go_resolve) begin
      g_q <= (idx_q < n_q) ? GLYPH_AW'(idx_q) : fallback_sel;
      j_q <= '0;
    end
    if (go_emit) begin
      out_addr_q   <= acc_q;
      out_mask_q   <= bmp_rdata;
      out_pix_q    <= w_q;
      out_text_q   <= tcol_q;
      out_fill_q   <= back_q;
      out_last_q   <= row_last;
      out_scroll_q <= row_last && scroll_q;
      out_esc_q    <= 1'b0;
      j_q          <= j_q + ROW_AW'(1);
      acc_q        <= acc_q + ADDR_W'(cfg_i.frame_pitch);
    end
    if (go_esc) begin
      out_addr_q   <= '0;
      out_mask_q   <= '0;
      out_pix_q    <= '0;
      out_text_q   <= '0;
      out_fill_q   <= '0;
      out_last_q   <= 1'b1;
      out_scroll_q <= 1'b0;
      out_esc_q    <= 1'b1;
    end
  end

  // Status back to the sequencer.
  assign status_o.in_valid  = cmd_in.valid;
  assign status_o.is_draw   = (cmd_q == CMD_DRAW);
  assign status_o.is_esc    = (code_q == ESC_CODE);
  assign status_o.searching = searching;
  assign status_o.row_more  = !row_last;
  assign status_o.out_busy  = out_valid_q && !row_out.ready;

  // Output word.
  assign row_out.valid          = out_valid_q;
  assign row_out.pixel_address  = out_addr_q;
  assign row_out.pixel_mask     = out_mask_q;
  assign row_out.row_pixels     = out_pix_q;
  assign row_out.text_color     = out_text_q;
  assign row_out.fill_color     = out_fill_q;
  assign row_out.last_row       = out_last_q;
  assign row_out.scroll_request = out_scroll_q;
  assign row_out.escape_seen    = out_esc_q;

`ifndef SYNTHESIS
  // A scroll request only rides on the final word of a character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_out.valid && row_out.scroll_request |-> row_out.last_row)
    else $error("scroll request on a word that is not the last");

  // An escape word is a single flag-only word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_out.valid && row_out.escape_seen |-> row_out.last_row && (row_out.row_pixels == '0))
    else $error("escape word carries pixels or is not last");

  // Rows are only emitted inside the clamped glyph height.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_emit |-> (HGT_W'(j_q) < h_q))
    else $error("row counter ran past the glyph height");

  // After a cursor update the line lies on the screen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_offset |=> (cur_line_q < cfg_i.text_rows) || (cur_line_q == '0))
    else $error("cursor line left the screen");
`endif

endmodule

@@ sim/tb_text_glyph_row_renderer.sv @@
// ----------------------------------------------------------------------------
// tb_text_glyph_row_renderer: self-checking bench for the glyph row renderer
// Loads glyph codes and bitmap rows, draws characters under a series of
// register settings, and checks every row word against a cycle-free
// prediction of addresses, masks, colors, cursor wrap and scroll flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_text_glyph_row_renderer;
  import tgr_pkg::*;

  localparam int HOLD_CYCLES   = 600;
  localparam int SETTLE_CYCLES = 320;
  localparam int REPORT_LIMIT  = 10;

  localparam logic [CMD_W-1:0]     CMD_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd15;

  // One command word as the sender offers it.
  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [CODE_W-1:0]   char_code;
    logic [COLOR_W-1:0]  fore_color;
    logic [COLOR_W-1:0]  back_color;
    logic                bold;
    logic [GLYPH_AW-1:0] entry_index;
    logic [ROW_AW-1:0]   row_index;
    logic [BITS_W-1:0]   row_bits;
  } cmd_word_t;

  // One row word as the block emits it.
  typedef struct packed {
    logic [ADDR_W-1:0]  pixel_address;
    logic [BITS_W-1:0]  pixel_mask;
    logic [PIX_W-1:0]   row_pixels;
    logic [COLOR_W-1:0] text_color;
    logic [COLOR_W-1:0] fill_color;
    logic               last_row;
    logic               scroll_request;
    logic               escape_seen;
  } row_word_t;

  // Tracks glyph tables, registers and cursor, and the row words still due.
  class glyph_row_tracker;
    int unsigned     reg_width, reg_height, reg_spacing, reg_columns;
    int unsigned     reg_rows, reg_pitch, reg_count, reg_fallback;
    bit [CODE_W-1:0] code_tab [MAX_GLYPHS];
    bit              code_set [MAX_GLYPHS];
    bit [BITS_W-1:0] bmp_tab [BMP_DEPTH];
    bit              bmp_set [BMP_DEPTH];
    int unsigned     cur_col, cur_line;
    row_word_t       rows_due [$];
    int              errors;

    function new();
      reg_width    = 8;
      reg_height   = 16;
      reg_spacing  = 0;
      reg_columns  = 80;
      reg_rows     = 25;
      reg_pitch    = 1024;
      reg_count    = 0;
      reg_fallback = 0;
      cur_col      = 0;
      cur_line     = 0;
      errors       = 0;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_GLYPH_WIDTH:    reg_width    = data[PIX_W-1:0];
        REG_GLYPH_HEIGHT:   reg_height   = data[HGT_W-1:0];
        REG_CHAR_SPACING:   reg_spacing  = data[SPACE_W-1:0];
        REG_TEXT_COLUMNS:   reg_columns  = data[CELLS_W-1:0];
        REG_TEXT_ROWS:      reg_rows     = data[CELLS_W-1:0];
        REG_FRAME_PITCH:    reg_pitch    = data[PITCH_W-1:0];
        REG_GLYPH_COUNT:    reg_count    = data[COUNT_W-1:0];
        REG_FALLBACK_GLYPH: reg_fallback = data[CODE_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned cell_width();
      if (reg_width < 1) return 1;
      if (reg_width > WIDTH_MAX) return WIDTH_MAX;
      return reg_width;
    endfunction

    function int unsigned rows_per_glyph();
      if (reg_height < 1) return 1;
      if (reg_height > ROW_LIMIT) return ROW_LIMIT;
      return reg_height;
    endfunction

    function int unsigned searched_entries();
      return (reg_count > MAX_GLYPHS) ? MAX_GLYPHS : reg_count;
    endfunction

    // First searched entry holding the code, else the fallback entry.
    function int unsigned resolve_entry(input logic [CODE_W-1:0] code);
      for (int unsigned g = 0; g < searched_entries(); g++) begin
        if (code_tab[g] == code) return g;
      end
      return (reg_fallback >= MAX_GLYPHS) ? 0 : reg_fallback;
    endfunction

    // Per-byte saturating brightening of the text color.
    function logic [COLOR_W-1:0] bold_color(input logic [COLOR_W-1:0] c);
      logic [COLOR_W-1:0] r;
      logic [7:0]         v;
      r = '0;
      for (int b = 0; b < COLOR_W / 8; b++) begin
        v = c[8*b +: 8];
        r[8*b +: 8] = (v > BYTE_MAX - BOLD_ADD) ? BYTE_MAX : v + BOLD_ADD;
      end
      return r;
    endfunction

    // Applies one accepted command word and queues the rows it produces.
    function void take_word(input cmd_word_t w);
      row_word_t          e;
      int unsigned        w_px, h, g, col, line, slot;
      bit                 scroll;
      longint unsigned    addr;
      logic [COLOR_W-1:0] tcol;
      case (w.command)
        CMD_LOAD_CODE: begin
          code_tab[w.entry_index] = w.char_code;
          code_set[w.entry_index] = 1'b1;
        end
        CMD_LOAD_ROW: begin
          slot = int'(w.entry_index) * MAX_GLYPH_ROWS + int'(w.row_index);
          bmp_tab[slot] = w.row_bits;
          bmp_set[slot] = 1'b1;
        end
        CMD_DRAW: begin
          if (w.char_code == ESC_CODE) begin
            // Escape draws nothing and leaves the cursor alone.
            e = '0;
            e.last_row = 1'b1;
            e.escape_seen = 1'b1;
            rows_due.push_back(e);
          end else begin
            tcol = w.bold ? bold_color(w.fore_color) : w.fore_color;
            w_px = cell_width();
            h = rows_per_glyph();
            g = resolve_entry(w.char_code);
            col = cur_col + 1;
            line = cur_line;
            scroll = 1'b0;
            if (col >= reg_columns) begin
              col = 0;
              line++;
            end
            if (line >= reg_rows) begin
              scroll = 1'b1;
              line = (reg_rows != 0) ? reg_rows - 1 : 0;
            end
            for (int unsigned j = 0; j < h; j++) begin
              addr = (64'(cur_line) * h + j) * reg_pitch
                   + 64'(cur_col) * (w_px + reg_spacing);
              e.pixel_address  = addr[ADDR_W-1:0];
              e.pixel_mask     = bmp_tab[g * MAX_GLYPH_ROWS + j];
              e.row_pixels     = w_px[PIX_W-1:0];
              e.text_color     = tcol;
              e.fill_color     = w.back_color;
              e.last_row       = (j == h - 1);
              e.scroll_request = (j == h - 1) && scroll;
              e.escape_seen    = 1'b0;
              rows_due.push_back(e);
            end
            cur_col = col & 8'hFF;
            cur_line = line & 8'hFF;
          end
        end
        default: ;
      endcase
    endfunction

    // Compares one accepted row word with the oldest one due.
    function void match_row(input row_word_t got);
      row_word_t e;
      if (rows_due.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("row word with none due: addr %h mask %h pix %0d last %b esc %b",
                   got.pixel_address, got.pixel_mask, got.row_pixels, got.last_row,
                   got.escape_seen);
        return;
      end
      e = rows_due.pop_front();
      if (got !== e) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("row mismatch exp: addr %h mask %h pix %0d text %h fill %h l/s/e %b%b%b",
                   e.pixel_address, e.pixel_mask, e.row_pixels, e.text_color,
                   e.fill_color, e.last_row, e.scroll_request, e.escape_seen);
          $display("             got: addr %h mask %h pix %0d text %h fill %h l/s/e %b%b%b",
                   got.pixel_address, got.pixel_mask, got.row_pixels, got.text_color,
                   got.fill_color, got.last_row, got.scroll_request, got.escape_seen);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  tgr_cmd_if cmd_bus ();
  tgr_row_if row_bus ();
  tgr_cfg_if cfg_bus ();

  text_glyph_row_renderer uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_in  (cmd_bus),
    .row_out (row_bus),
    .cfg_in  (cfg_bus)
  );

  glyph_row_tracker tracker;
  bit               hold_req;
  int unsigned      sent_words;
  int unsigned      rows_seen;

  // Clock, 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Idle cycles before a word, with stretches of back-to-back traffic.
  function automatic int unsigned pick_gap(input int unsigned count);
    if ((count / 48) % 4 == 3) return 0;
    return $urandom_range(0, 7);
  endfunction

  function automatic logic [CODE_W-1:0] pick_code();
    if ($urandom_range(0, 1) != 0) return 8'h41 + 8'($urandom_range(0, 5));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic cmd_word_t noise_word();
    cmd_word_t w;
    w.command     = 2'($urandom_range(0, 3));
    w.char_code   = 8'($urandom_range(0, 255));
    w.fore_color  = $urandom;
    w.back_color  = $urandom;
    w.bold        = 1'($urandom_range(0, 1));
    w.entry_index = 8'($urandom_range(0, 255));
    w.row_index   = 4'($urandom_range(0, 15));
    w.row_bits    = 8'($urandom_range(0, 255));
    return w;
  endfunction

  function automatic cmd_word_t make_code_load(input logic [GLYPH_AW-1:0] entry,
                                               input logic [CODE_W-1:0] code);
    cmd_word_t w;
    w = noise_word();
    w.command = CMD_LOAD_CODE;
    w.entry_index = entry;
    w.char_code = code;
    return w;
  endfunction

  function automatic cmd_word_t make_row_load(input logic [GLYPH_AW-1:0] entry,
                                              input logic [ROW_AW-1:0] row,
                                              input logic [BITS_W-1:0] bits);
    cmd_word_t w;
    w = noise_word();
    w.command = CMD_LOAD_ROW;
    w.entry_index = entry;
    w.row_index = row;
    w.row_bits = bits;
    return w;
  endfunction

  function automatic cmd_word_t make_draw(input logic [CODE_W-1:0] code,
                                          input logic [COLOR_W-1:0] fore,
                                          input logic [COLOR_W-1:0] back,
                                          input logic bold);
    cmd_word_t w;
    w = noise_word();
    w.command = CMD_DRAW;
    w.char_code = code;
    w.fore_color = fore;
    w.back_color = back;
    w.bold = bold;
    return w;
  endfunction

  // Offers one command word after a random gap and waits for its acceptance.
  task automatic push_word(input cmd_word_t w);
    int unsigned gap;
    gap = pick_gap(sent_words);
    @(negedge clk_i);
    if (gap != 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_bus.command     <= w.command;
    cmd_bus.char_code   <= w.char_code;
    cmd_bus.fore_color  <= w.fore_color;
    cmd_bus.back_color  <= w.back_color;
    cmd_bus.bold        <= w.bold;
    cmd_bus.entry_index <= w.entry_index;
    cmd_bus.row_index   <= w.row_index;
    cmd_bus.row_bits    <= w.row_bits;
    cmd_bus.valid       <= 1'b1;
    do @(posedge clk_i); while (cmd_bus.ready !== 1'b1);
    tracker.take_word(w);
    sent_words++;
  endtask

  // Draws a character, first loading any bitmap row the draw would read unset.
  task automatic draw_word(input cmd_word_t w);
    int unsigned g, h, slot;
    if (w.char_code != ESC_CODE) begin
      g = tracker.resolve_entry(w.char_code);
      h = tracker.rows_per_glyph();
      for (int unsigned j = 0; j < h; j++) begin
        slot = g * MAX_GLYPH_ROWS + j;
        if (!tracker.bmp_set[slot])
          push_word(make_row_load(g[GLYPH_AW-1:0], j[ROW_AW-1:0],
                                  8'($urandom_range(0, 255))));
      end
    end
    push_word(w);
  endtask

  // Drops valid and waits until the block has delivered everything and gone quiet.
  task automatic drain();
    @(negedge clk_i);
    cmd_bus.valid <= 1'b0;
    while (tracker.rows_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(negedge clk_i);
    cfg_bus.index <= idx;
    cfg_bus.data  <= value[CFG_DATA_W-1:0];
    cfg_bus.valid <= 1'b1;
    do @(posedge clk_i); while (cfg_bus.ready !== 1'b1);
    tracker.write_reg(idx, value[CFG_DATA_W-1:0]);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  // New register setting, then codes for every searched entry not yet loaded.
  task automatic setup_phase(input int unsigned w, input int unsigned h,
                             input int unsigned sp, input int unsigned cols,
                             input int unsigned rows, input int unsigned pitch,
                             input int unsigned count, input int unsigned fb);
    drain();
    write_reg(REG_GLYPH_WIDTH, w);
    write_reg(REG_GLYPH_HEIGHT, h);
    write_reg(REG_CHAR_SPACING, sp);
    write_reg(REG_TEXT_COLUMNS, cols);
    write_reg(REG_TEXT_ROWS, rows);
    write_reg(REG_FRAME_PITCH, pitch);
    write_reg(REG_GLYPH_COUNT, count);
    write_reg(REG_FALLBACK_GLYPH, fb);
    for (int unsigned e = 0; e < tracker.searched_entries(); e++) begin
      if (!tracker.code_set[e]) push_word(make_code_load(e[GLYPH_AW-1:0], pick_code()));
    end
  endtask

  // Mostly draws of known codes, mixed with loads, escapes and unused commands.
  task automatic random_items(input int unsigned count);
    int unsigned done, pick, n;
    cmd_word_t   w;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      n = tracker.searched_entries();
      w = noise_word();
      if (pick < 62) begin
        w.command = CMD_DRAW;
        if (n != 0 && $urandom_range(0, 1) != 0)
          w.char_code = tracker.code_tab[$urandom_range(0, n - 1)];
        draw_word(w);
        done++;
      end else if (pick < 68) begin
        w.command = CMD_DRAW;
        w.char_code = ESC_CODE;
        draw_word(w);
        done++;
      end else if (pick < 80) begin
        w.command = CMD_LOAD_ROW;
        push_word(w);
        done++;
      end else if (pick < 90) begin
        w.command = CMD_LOAD_CODE;
        w.char_code = pick_code();
        push_word(w);
        done++;
      end else begin
        w.command = CMD_UNUSED;
        push_word(w);
      end
    end
  endtask

  // Row sink: random back-pressure, long hold-offs on request, checks each word.
  initial begin : row_sink
    int unsigned gap_left;
    row_word_t   got;
    row_bus.ready = 1'b0;
    gap_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        row_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      if (gap_left != 0) begin
        row_bus.ready <= 1'b0;
        gap_left--;
      end else begin
        row_bus.ready <= 1'b1;
      end
      @(posedge clk_i);
      if (row_bus.valid === 1'b1 && row_bus.ready === 1'b1) begin
        got.pixel_address  = row_bus.pixel_address;
        got.pixel_mask     = row_bus.pixel_mask;
        got.row_pixels     = row_bus.row_pixels;
        got.text_color     = row_bus.text_color;
        got.fill_color     = row_bus.fill_color;
        got.last_row       = row_bus.last_row;
        got.scroll_request = row_bus.scroll_request;
        got.escape_seen    = row_bus.escape_seen;
        tracker.match_row(got);
        rows_seen++;
        gap_left = pick_gap(rows_seen);
      end
    end
  end

  // Stimulus: reset, directed words, then randomized phases under many settings.
  initial begin : stimulus
    tracker = new();
    hold_req = 1'b0;
    sent_words = 0;
    rows_seen = 0;
    rst_ni = 1'b0;
    cmd_bus.valid = 1'b0;
    cmd_bus.command = CMD_DRAW;
    cmd_bus.char_code = '0;
    cmd_bus.fore_color = '0;
    cmd_bus.back_color = '0;
    cmd_bus.bold = 1'b0;
    cmd_bus.entry_index = '0;
    cmd_bus.row_index = '0;
    cmd_bus.row_bits = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_GLYPH_WIDTH;
    cfg_bus.data = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: table extremes, bold saturation, fallback, escape, scroll.
    setup_phase(8, 2, 0, 3, 2, 1024, 1, 255);
    push_word(make_code_load(8'd0, 8'h41));
    push_word(make_code_load(8'd255, 8'hFF));
    push_word(make_row_load(8'd0, 4'd0, 8'h80));
    push_word(make_row_load(8'd0, 4'd1, 8'h01));
    push_word(make_row_load(8'd255, 4'd0, 8'hFF));
    push_word(make_row_load(8'd255, 4'd1, 8'h00));
    push_word(make_row_load(8'd255, 4'd15, 8'hAA));
    draw_word(make_draw(8'h41, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1));
    draw_word(make_draw(8'h41, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1));
    draw_word(make_draw(8'h41, 32'hAAAA_AAAA, 32'h1234_5678, 1'b1));
    draw_word(make_draw(8'hFF, 32'h0123_4567, 32'h89AB_CDEF, 1'b0));
    draw_word(make_draw(ESC_CODE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    begin
      cmd_word_t w;
      w = noise_word();
      w.command = CMD_UNUSED;
      push_word(w);
    end
    draw_word(make_draw(8'h00, 32'hAB00_AB56, 32'h5555_AAAA, 1'b1));
    draw_word(make_draw(8'h41, 32'h8080_8080, 32'h7F7F_7F7F, 1'b0));
    draw_word(make_draw(8'h41, 32'h0000_00AA, 32'hFFFF_0000, 1'b1));
    draw_word(make_draw(8'h41, 32'hCAFE_F00D, 32'h0000_FFFF, 1'b0));

    // Smallest legal settings.
    setup_phase(1, 1, 7, 1, 1, 1, 4, 0);
    random_items(40);
    // Zero and out-of-range register values.
    setup_phase(0, 0, 0, 0, 0, 0, 0, 7);
    random_items(30);
    // One cell per line, so the cursor walks far down the screen.
    setup_phase(3, 1, 2, 1, 255, 100, 2, 1);
    random_items(200);
    // Tallest glyphs and widest pitch push addresses past the 24-bit range.
    setup_phase(15, 31, 5, 1, 255, 8191, 16, 255);
    hold_req = 1'b1;
    random_items(50);
    // Largest legal settings with a long output stall.
    setup_phase(8, 16, 7, 255, 255, 4096, 8, 3);
    hold_req = 1'b1;
    random_items(30);
    // Full table search.
    setup_phase(5, 3, 1, 10, 4, 640, 256, 200);
    random_items(40);
    // Glyph count beyond the table; a write to an unused register index.
    setup_phase(7, 17, 4, 6, 3, 333, 511, 100);
    write_reg(REG_UNUSED, 13'h1FFF);
    random_items(40);

    drain();
    if (tracker.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

@@ files.f @@
rtl/tgr_pkg.sv
rtl/tgr_chan_if.sv
rtl/tgr_ram.sv
rtl/tgr_sequencer.sv
rtl/tgr_datapath.sv
rtl/text_glyph_row_renderer.sv
sim/tb_text_glyph_row_renderer.sv
